// ===== hdl/ovng_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ovng_pkg
// Shared types and constants of the octave value noise generator.
// ----------------------------------------------------------------------------
package ovng_pkg;

  localparam int GRID_SIZE_DEF = 256;

  localparam int SEED_W  = 16;
  localparam int SCALE_W = 32;
  localparam int SUM_W   = 52;
  localparam int WTS_W   = 36;

  localparam logic [3:0]         OCT_COUNT_RESET   = 4'd8;
  localparam logic [15:0]        OCT_FALLOFF_RESET = 16'd512;
  localparam logic [SCALE_W-1:0] SCALE_ONE         = 32'h0001_0000;
  localparam logic [SCALE_W-1:0] SCALE_MAX         = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REG_OCTAVE_COUNT   = 2'd0,
    REG_OCTAVE_FALLOFF = 2'd1
  } reg_index_t;

  typedef struct packed {
    logic [3:0]  count;
    logic [15:0] falloff;
  } cfg_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_OCT  = 11'b00000000010,
    S_RD   = 11'b00000000100,
    S_B1   = 11'b00000001000,
    S_B2   = 11'b00000010000,
    S_B3   = 11'b00000100000,
    S_B4   = 11'b00001000000,
    S_B5   = 11'b00010000000,
    S_WAIT = 11'b00100000000,
    S_NORM = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/ovng_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ovng_front
// Accepts input transactions, folds positions onto the grid and queues them.
// ----------------------------------------------------------------------------
module ovng_front #(
  parameter int GRID_SIZE = ovng_pkg::GRID_SIZE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output      logic                             full,
  input  wire logic                             kind,
  input  wire logic [7:0]                       pos_x,
  input  wire logic [7:0]                       pos_y,
  input  wire logic [ovng_pkg::SEED_W-1:0]      seed_value,
  output      logic                             item_valid,
  input  wire logic                             item_take,
  output      logic                             item_query,
  output      logic [$clog2(GRID_SIZE)-1:0]     item_x,
  output      logic [$clog2(GRID_SIZE)-1:0]     item_y,
  output      logic [ovng_pkg::SEED_W-1:0]      item_seed
);
  import ovng_pkg::*;

  localparam int LOG = $clog2(GRID_SIZE);

  logic [LOG+7:0] x_ext, y_ext;
  logic           q_query [2];
  logic [LOG-1:0] q_x     [2];
  logic [LOG-1:0] q_y     [2];
  logic [SEED_W-1:0] q_seed [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;
  logic           do_push, do_pop;

  // fold the position modulo the grid size
  assign x_ext = {{LOG{1'b0}}, pos_x};
  assign y_ext = {{LOG{1'b0}}, pos_y};

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  assign item_query = q_query[rd_ptr];
  assign item_x     = q_x[rd_ptr];
  assign item_y     = q_y[rd_ptr];
  assign item_seed  = q_seed[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_query[wr_ptr] <= kind;
      q_x[wr_ptr]     <= x_ext[LOG-1:0];
      q_y[wr_ptr]     <= y_ext[LOG-1:0];
      q_seed[wr_ptr]  <= seed_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ovng_scale_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ovng_scale_div
// Next octave weight: floor(scale * 256 / falloff), saturated, four bits a cycle.
// ----------------------------------------------------------------------------
module ovng_scale_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ovng_pkg::SCALE_W-1:0]  scale,
  input  wire logic [15:0]                   falloff,
  output      logic                          done,
  output      logic [ovng_pkg::SCALE_W-1:0]  quot
);
  import ovng_pkg::*;

  localparam int DD_W  = SCALE_W + 8;
  localparam int BITS  = 4;
  localparam int STEPS = DD_W / BITS;

  logic [DD_W-1:0] dd, dd_next, q, q_next;
  logic [15:0]     rem, rem_next;
  logic [3:0]      steps;
  logic            busy;

  always_comb begin
    logic [16:0] t;
    rem_next = rem;
    dd_next  = dd;
    q_next   = q;
    for (int j = 0; j < BITS; j++) begin
      t       = {rem_next, dd_next[DD_W-1]};
      dd_next = {dd_next[DD_W-2:0], 1'b0};
      if (t >= {1'b0, falloff}) begin
        rem_next = 16'(t - {1'b0, falloff});
        q_next   = {q_next[DD_W-2:0], 1'b1};
      end else begin
        rem_next = t[15:0];
        q_next   = {q_next[DD_W-2:0], 1'b0};
      end
    end
  end

  assign quot = (q[DD_W-1:SCALE_W] != '0) ? SCALE_MAX : q[SCALE_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      dd  <= {scale, 8'd0};
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      dd  <= dd_next;
      rem <= rem_next;
      q   <= q_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      steps <= 4'(STEPS);
    end else if (busy) begin
      steps <= steps - 4'd1;
      if (steps == 4'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ovng_norm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ovng_norm_div
// Normalize: weighted sum over weight sum, sixteen quotient bits, one a cycle.
// ----------------------------------------------------------------------------
module ovng_norm_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [ovng_pkg::SUM_W-1:0]  sum,
  input  wire logic [ovng_pkg::WTS_W-1:0]  wts,
  output      logic                        done,
  output      logic [15:0]                 quot
);
  import ovng_pkg::*;

  logic [SUM_W-1:0] rem, dvs;
  logic [4:0]       steps;
  logic             busy, fits;

  assign fits = (rem >= dvs);

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= sum;
      dvs  <= {{(SUM_W-WTS_W){1'b0}}, wts} << 15;
      quot <= '0;
    end else if (busy) begin
      if (fits) rem <= rem - dvs;
      quot <= {quot[14:0], fits};
      dvs  <= dvs >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      steps <= 5'd16;
    end else if (busy) begin
      steps <= steps - 5'd1;
      if (steps == 5'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ovng_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ovng_back
// Seed memory and the octave sequencer: corner reads, blend, weight, normalize.
// ----------------------------------------------------------------------------
module ovng_back #(
  parameter int GRID_SIZE = ovng_pkg::GRID_SIZE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ovng_pkg::cfg_t               cfg,
  input  wire logic                         item_valid,
  output      logic                         item_take,
  input  wire logic                         item_query,
  input  wire logic [$clog2(GRID_SIZE)-1:0] item_x,
  input  wire logic [$clog2(GRID_SIZE)-1:0] item_y,
  input  wire logic [ovng_pkg::SEED_W-1:0]  item_seed,
  output      logic                         empty,
  input  wire logic                         pop,
  output      logic [15:0]                  noise_value
);
  import ovng_pkg::*;

  localparam int LOG    = $clog2(GRID_SIZE);
  localparam int ADDR_W = 2 * LOG;
  localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
  localparam int P_W    = LOG + 1;
  localparam int TOP_W  = SEED_W + LOG;
  localparam int V_W    = SEED_W + 2 * LOG;
  localparam int K_W    = $clog2(LOG + 1);

  logic [SEED_W-1:0] mem [DEPTH];
  logic [SEED_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en, wr_en;

  state_t            state;
  logic [LOG-1:0]    qx, qy;
  logic [3:0]        oct, cnt;
  logic [15:0]       fall;
  logic [SCALE_W-1:0] scale;
  logic [SUM_W-1:0]  sum;
  logic [WTS_W-1:0]  wts;
  logic [2:0]        rd_idx;
  logic [SEED_W-1:0] s_c [4];
  logic [TOP_W-1:0]  top_r, bot_r;
  logic [V_W-1:0]    v_r;
  logic [15:0]       ov_r;
  logic              out_valid;

  logic [K_W-1:0]    k;
  logic [P_W-1:0]    p, wx0, wx1, wy0, wy1;
  logic [LOG-1:0]    pm, dx, dy, x1, y1, x2, y2;
  logic [SEED_W-1:0] ma, mb;
  logic [TOP_W:0]    blend_full;
  logic [V_W:0]      v_full;
  logic [V_W-1:0]    v_shift;
  logic [47:0]       prod;
  logic              sdiv_start, sdiv_done, ndiv_start, ndiv_done, last_oct;
  logic [SCALE_W-1:0] sdiv_q;
  logic [15:0]       ndiv_q;

  // pitch for this octave, never below one
  assign k   = ({28'd0, oct} < LOG) ? K_W'(LOG - int'(oct)) : '0;
  assign p   = P_W'(1) << k;
  assign pm  = LOG'(p - P_W'(1));
  assign dx  = qx & pm;
  assign dy  = qy & pm;
  assign x1  = qx & ~pm;
  assign y1  = qy & ~pm;
  assign x2  = x1 + p[LOG-1:0];
  assign y2  = y1 + p[LOG-1:0];
  assign wx0 = p - {1'b0, dx};
  assign wx1 = {1'b0, dx};
  assign wy0 = p - {1'b0, dy};
  assign wy1 = {1'b0, dy};

  assign rd_addr = {rd_idx[1] ? y2 : y1, rd_idx[0] ? x2 : x1};
  assign rd_en   = (state == S_RD) && (rd_idx != 3'd4);
  assign item_take = (state == S_IDLE) && item_valid;
  assign wr_en   = item_take && !item_query;

  always_ff @(posedge clk) begin
    if (wr_en) mem[{item_y, item_x}] <= item_seed;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // one blend unit: top row in B1, bottom row in B2
  assign ma         = (state == S_B1) ? s_c[0] : s_c[2];
  assign mb         = (state == S_B1) ? s_c[1] : s_c[3];
  assign blend_full = wx0 * ma + wx1 * mb;
  assign v_full     = wy0 * top_r + wy1 * bot_r;
  assign v_shift    = v_r >> {k, 1'b0};
  assign prod       = ov_r * scale;

  assign sdiv_start = (state == S_OCT);
  assign last_oct   = ((oct + 4'd1) == cnt);
  assign ndiv_start = (state == S_WAIT) && sdiv_done && last_oct;

  ovng_scale_div u_sdiv (
    .clk     (clk),
    .rst     (rst),
    .start   (sdiv_start),
    .scale   (scale),
    .falloff (fall),
    .done    (sdiv_done),
    .quot    (sdiv_q)
  );

  ovng_norm_div u_ndiv (
    .clk   (clk),
    .rst   (rst),
    .start (ndiv_start),
    .sum   (sum),
    .wts   (wts),
    .done  (ndiv_done),
    .quot  (ndiv_q)
  );

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (item_take && item_query) begin
          qx    <= item_x;
          qy    <= item_y;
          cnt   <= (cfg.count == 4'd0) ? 4'd1 : cfg.count;
          fall  <= (cfg.falloff == 16'd0) ? 16'd1 : cfg.falloff;
          scale <= SCALE_ONE;
          sum   <= '0;
          wts   <= '0;
          oct   <= '0;
        end
      end
      S_OCT: rd_idx <= '0;
      S_RD: begin
        rd_idx <= rd_idx + 3'd1;
        if (rd_idx != 3'd0) s_c[2'(rd_idx - 3'd1)] <= rd_data;
      end
      S_B1: top_r <= blend_full[TOP_W-1:0];
      S_B2: bot_r <= blend_full[TOP_W-1:0];
      S_B3: v_r   <= v_full[V_W-1:0];
      S_B4: ov_r  <= v_shift[15:0];
      S_B5: begin
        sum <= sum + {4'd0, prod};
        wts <= wts + {4'd0, scale};
      end
      S_WAIT: begin
        if (sdiv_done) begin
          scale <= sdiv_q;
          oct   <= oct + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drop the popped result unless the finish step refills the slot
      if (pop && out_valid && (state != S_DONE)) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (item_take && item_query) state <= S_OCT;
        S_OCT:  state <= S_RD;
        S_RD:   if (rd_idx == 3'd4) state <= S_B1;
        S_B1:   state <= S_B2;
        S_B2:   state <= S_B3;
        S_B3:   state <= S_B4;
        S_B4:   state <= S_B5;
        S_B5:   state <= S_WAIT;
        S_WAIT: if (sdiv_done) state <= last_oct ? S_NORM : S_OCT;
        S_NORM: if (ndiv_done) state <= S_DONE;
        S_DONE: begin
          if (!out_valid || pop) begin
            out_valid   <= 1'b1;
            noise_value <= ndiv_q;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign empty = !out_valid;

`ifndef SYNTHESIS
  a_oct_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_B5) |-> (oct < cnt))
    else $error("octave index past count");
  a_wts_nonzero: assert property (@(posedge clk) disable iff (rst)
    ndiv_start |-> (wts != '0))
    else $error("normalize with zero weight sum");
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside finish step");
`endif

endmodule
`default_nettype wire

// ===== hdl/octave_value_noise_generator.sv =====
`default_nettype none
// Order: a load is written into seed memory when the idle sequencer takes it from
// the front queue; a query result for N octaves follows its transaction after four
// seed reads, five blend and weight steps and one scale update per octave, then
// the normalizing divider and result handoff.
// Throughput: one query at a time; loads stream at one per cycle when idle.
// Reset (rst, synchronous, active high) empties both queues and restores the
// octave registers; seed memory contents stay undefined until loaded.
// ----------------------------------------------------------------------------
// octave_value_noise_generator
// Octave-summed bilinear value noise over a loadable square seed grid.
// ----------------------------------------------------------------------------
module octave_value_noise_generator #(
  parameter int GRID_SIZE = ovng_pkg::GRID_SIZE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output      logic                        full,
  input  wire logic                        kind,
  input  wire logic [7:0]                  pos_x,
  input  wire logic [7:0]                  pos_y,
  input  wire logic [ovng_pkg::SEED_W-1:0] seed_value,
  output      logic                        empty,
  input  wire logic                        pop,
  output      logic [15:0]                 noise_value,
  input  wire logic                        cfg_write,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [15:0]                 cfg_data
);
  import ovng_pkg::*;

  localparam int LOG = $clog2(GRID_SIZE);

  cfg_t              cfg;
  logic              item_valid, item_take, item_query;
  logic [LOG-1:0]    item_x, item_y;
  logic [SEED_W-1:0] item_seed;

  // configuration registers; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count   <= OCT_COUNT_RESET;
      cfg.falloff <= OCT_FALLOFF_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OCTAVE_COUNT:   cfg.count   <= cfg_data[3:0];
        REG_OCTAVE_FALLOFF: cfg.falloff <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: take the transaction, fold position, hold it in a two-deep queue
  ovng_front #(.GRID_SIZE(GRID_SIZE)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .seed_value (seed_value),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item_query (item_query),
    .item_x     (item_x),
    .item_y     (item_y),
    .item_seed  (item_seed)
  );

  // back: write loads, run queries through the octave sequencer
  ovng_back #(.GRID_SIZE(GRID_SIZE)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .item_take   (item_take),
    .item_query  (item_query),
    .item_x      (item_x),
    .item_y      (item_y),
    .item_seed   (item_seed),
    .empty       (empty),
    .pop         (pop),
    .noise_value (noise_value)
  );

endmodule
`default_nettype wire
